[design/sbcf_pkg.sv]
// Shared constants, types and helpers for the stack backtrace code filter.
package sbcf_pkg;

   localparam int DEF_MAX_ENTRIES = 16;
   localparam int DEF_SCAN_WORDS  = 128;

   localparam int WORD_W  = 32;
   localparam int INDEX_W = 4;
   localparam int CSR_W   = 2;

   localparam logic [WORD_W-1:0] RST_CODE_BASE = 32'h0800_0000;
   localparam logic [WORD_W-1:0] RST_CODE_END  = 32'h0810_0000;
   localparam logic [WORD_W-1:0] RST_RAM_BASE  = 32'h2000_0000;
   localparam logic [WORD_W-1:0] RST_RAM_END   = 32'h2002_0000;

   localparam logic [CSR_W-1:0] CSR_CODE_BASE = 2'd0;
   localparam logic [CSR_W-1:0] CSR_CODE_END  = 2'd1;
   localparam logic [CSR_W-1:0] CSR_RAM_BASE  = 2'd2;
   localparam logic [CSR_W-1:0] CSR_RAM_END   = 2'd3;

   localparam logic REQ_START = 1'b0;
   localparam logic REQ_WORD  = 1'b1;

   typedef struct packed {
      logic load;    // latch the accepted transaction
      logic eval;    // evaluate it and commit list state
      logic show1;   // present the second result
   } ctrl_cmd_type;

   typedef struct packed {
      logic [1:0] eval_count;  // results the item in evaluation produces
      logic [1:0] held_count;  // results held for delivery
   } dp_status_type;

   function automatic logic is_code(input logic [WORD_W-1:0] v,
                                    input logic [WORD_W-1:0] base,
                                    input logic [WORD_W-1:0] lim);
      return (v >= base) && (v < lim) && v[0];
   endfunction

endpackage

[design/sbcf_req_if.sv]
// Request channel: backtrace start or one stack word.
interface sbcf_req_if import sbcf_pkg::*; ();
   logic              valid;
   logic              ready;
   logic              req_type;
   logic [WORD_W-1:0] fault_pc;
   logic [WORD_W-1:0] link_value;
   logic [WORD_W-1:0] stack_pointer;
   logic [WORD_W-1:0] stack_word;

   modport source (output valid, req_type, fault_pc, link_value, stack_pointer, stack_word,
                   input ready);
   modport sink   (input valid, req_type, fault_pc, link_value, stack_pointer, stack_word,
                   output ready);
endinterface

[design/sbcf_rsp_if.sv]
// Response channel: one appended call-list entry.
interface sbcf_rsp_if import sbcf_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [WORD_W-1:0]  entry_address;
   logic [INDEX_W-1:0] entry_index;
   logic               last_of_item;
   logic               list_full;

   modport source (output valid, entry_address, entry_index, last_of_item, list_full,
                   input ready);
   modport sink   (input valid, entry_address, entry_index, last_of_item, list_full,
                   output ready);
endinterface

[design/sbcf_ctrl.sv]
// Sequencing state machine for the backtrace code filter.
module sbcf_ctrl import sbcf_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   input  dp_status_type status,
   output ctrl_cmd_type  cmd
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_EVAL = 2'd1;
   localparam logic [1:0] ST_OUT0 = 2'd2;
   localparam logic [1:0] ST_OUT1 = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_EVAL;
         end
         ST_EVAL: begin
            state_in = (status.eval_count == 2'd0) ? ST_IDLE : ST_OUT0;
         end
         ST_OUT0: begin
            if (rsp_ready) state_in = (status.held_count == 2'd2) ? ST_OUT1 : ST_IDLE;
         end
         ST_OUT1: begin
            if (rsp_ready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = (state_ff == ST_OUT0) || (state_ff == ST_OUT1);
   assign cmd.load  = req_ready && req_valid;
   assign cmd.eval  = (state_ff == ST_EVAL);
   assign cmd.show1 = (state_ff == ST_OUT1);

endmodule

[design/sbcf_datapath.sv]
// Item registers, call list, dedup compare, scan bookkeeping and result registers.
module sbcf_datapath import sbcf_pkg::*; #(
   parameter int MAX_ENTRIES = DEF_MAX_ENTRIES,
   parameter int SCAN_WORDS  = DEF_SCAN_WORDS
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_write_enable,
   input  logic [CSR_W-1:0]   csr_index,
   input  logic [WORD_W-1:0]  csr_data,
   input  logic               in_type,
   input  logic [WORD_W-1:0]  in_pc,
   input  logic [WORD_W-1:0]  in_lr,
   input  logic [WORD_W-1:0]  in_sp,
   input  logic [WORD_W-1:0]  in_word,
   input  ctrl_cmd_type       cmd,
   output dp_status_type      status,
   output logic [WORD_W-1:0]  out_address,
   output logic [INDEX_W-1:0] out_index,
   output logic               out_last,
   output logic               out_full
);

   localparam int CW         = $clog2(MAX_ENTRIES + 1);
   localparam int IW         = $clog2(MAX_ENTRIES);
   localparam int SW         = $clog2(SCAN_WORDS + 1);
   localparam int SPAN_BYTES = 4 * SCAN_WORDS;

   // configuration
   logic [WORD_W-1:0] code_base_ff, code_end_ff, ram_base_ff, ram_end_ff;

   // latched transaction
   logic              type_ff;
   logic [WORD_W-1:0] pc_ff, lr_ff, sp_ff, word_ff;

   // list state
   logic [WORD_W-1:0] list_ff [MAX_ENTRIES];
   logic [CW-1:0]     count_ff;
   logic [SW-1:0]     seen_ff;
   logic              scan_en_ff;

   // results
   logic [WORD_W-1:0] res0_addr_ff, res1_addr_ff;
   logic [IW-1:0]     res0_slot_ff, res1_slot_ff;
   logic [1:0]        res_count_ff;

   logic              pc_code, lr_code, word_code, dup, word_ok, word_app, scan_ok;
   logic [WORD_W:0]   span_end;
   logic [1:0]        res_count_in;
   logic [WORD_W-1:0] res0_addr_in;
   logic [IW-1:0]     res0_slot_in;
   logic [IW-1:0]     sel_slot;

   always_ff @(posedge clock) begin
      if (reset) begin
         code_base_ff <= RST_CODE_BASE;
         code_end_ff  <= RST_CODE_END;
         ram_base_ff  <= RST_RAM_BASE;
         ram_end_ff   <= RST_RAM_END;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_CODE_BASE: code_base_ff <= csr_data;
            CSR_CODE_END:  code_end_ff  <= csr_data;
            CSR_RAM_BASE:  ram_base_ff  <= csr_data;
            CSR_RAM_END:   ram_end_ff   <= csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         type_ff <= in_type;
         pc_ff   <= in_pc;
         lr_ff   <= in_lr;
         sp_ff   <= in_sp;
         word_ff <= in_word;
      end
   end

   assign pc_code   = is_code(pc_ff, code_base_ff, code_end_ff);
   assign lr_code   = is_code(lr_ff, code_base_ff, code_end_ff);
   assign word_code = is_code(word_ff, code_base_ff, code_end_ff);

   // compare the word against every filled slot at once
   always_comb begin
      dup = 1'b0;
      for (int j = 0; j < MAX_ENTRIES; j++) begin
         if ((CW'(j) < count_ff) && (list_ff[IW'(j)] == word_ff)) dup = 1'b1;
      end
   end

   assign word_ok  = scan_en_ff && (seen_ff < SW'(SCAN_WORDS)) &&
                     (count_ff < CW'(MAX_ENTRIES));
   assign word_app = word_ok && word_code && !dup;

   assign span_end = {1'b0, sp_ff} + (WORD_W+1)'(SPAN_BYTES);
   assign scan_ok  = (sp_ff >= ram_base_ff) && (sp_ff < ram_end_ff) &&
                     (span_end <= {1'b0, ram_end_ff});

   always_comb begin
      if (type_ff == REQ_START) begin
         res_count_in = {1'b0, pc_code} + {1'b0, lr_code};
         res0_addr_in = pc_code ? pc_ff : lr_ff;
         res0_slot_in = '0;
      end else begin
         res_count_in = {1'b0, word_app};
         res0_addr_in = word_ff;
         res0_slot_in = count_ff[IW-1:0];
      end
   end

   assign status.eval_count = res_count_in;
   assign status.held_count = res_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         seen_ff      <= '0;
         scan_en_ff   <= 1'b0;
         res_count_ff <= '0;
      end else if (cmd.eval) begin
         res_count_ff <= res_count_in;
         if (type_ff == REQ_START) begin
            count_ff   <= CW'(res_count_in);
            seen_ff    <= '0;
            scan_en_ff <= scan_ok;
         end else if (word_ok) begin
            seen_ff <= seen_ff + SW'(1);
            if (word_app) count_ff <= count_ff + CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.eval) begin
         res0_addr_ff <= res0_addr_in;
         res0_slot_ff <= res0_slot_in;
         res1_addr_ff <= lr_ff;
         res1_slot_ff <= IW'(1);
      end
   end

   // list write: start fills up to the first two slots, a new word goes to the next free slot
   always_ff @(posedge clock) begin
      if (cmd.eval) begin
         for (int j = 0; j < MAX_ENTRIES; j++) begin
            if (type_ff == REQ_START) begin
               if (j == 0 && (pc_code || lr_code)) list_ff[IW'(j)] <= res0_addr_in;
               if (j == 1 && pc_code && lr_code)   list_ff[IW'(j)] <= lr_ff;
            end else if (word_app && (count_ff == CW'(j))) begin
               list_ff[IW'(j)] <= word_ff;
            end
         end
      end
   end

   assign sel_slot    = cmd.show1 ? res1_slot_ff : res0_slot_ff;
   assign out_address = cmd.show1 ? res1_addr_ff : res0_addr_ff;
   assign out_index   = INDEX_W'(sel_slot);
   assign out_last    = cmd.show1 || (res_count_ff == 2'd1);
   assign out_full    = (sel_slot == IW'(MAX_ENTRIES - 1));

endmodule

[design/stack_backtrace_code_filter.sv]
// Top level of the stack backtrace code filter: controller plus datapath.
//
//  channel   direction  handshake       carries
//  req_chan  in         valid / ready   req_type, fault_pc, link_value, stack_pointer, stack_word
//  rsp_chan  out        valid / ready   entry_address, entry_index, last_of_item, list_full
//  csr_*     in         write enable    register index, 32-bit write data
//
// Each transaction is taken, then evaluated, then its results are handed out in turn
// while rsp_chan.ready is high: an item with no result hands out none, and a start that
// lists both pc and lr hands out two. The evaluate step does the window compares and the
// parallel duplicate check against every filled slot.
// Reset is synchronous and active high; it restores the register defaults and empties the
// list. A stalled response holds its payload and no new request is taken until it drains.
module stack_backtrace_code_filter import sbcf_pkg::*; #(
   parameter int MAX_ENTRIES = DEF_MAX_ENTRIES,
   parameter int SCAN_WORDS  = DEF_SCAN_WORDS
) (
   input  logic              clock,
   input  logic              reset,
   sbcf_req_if.sink          req_chan,
   sbcf_rsp_if.source        rsp_chan,
   input  logic              csr_write_enable,
   input  logic [CSR_W-1:0]  csr_index,
   input  logic [WORD_W-1:0] csr_data
);

   ctrl_cmd_type  cmd;
   dp_status_type status;

   // sequence each transaction: take, evaluate, hand out results
   sbcf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // hold the list, filter addresses and drive the response payload
   sbcf_datapath #(
      .MAX_ENTRIES (MAX_ENTRIES),
      .SCAN_WORDS  (SCAN_WORDS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .in_type          (req_chan.req_type),
      .in_pc            (req_chan.fault_pc),
      .in_lr            (req_chan.link_value),
      .in_sp            (req_chan.stack_pointer),
      .in_word          (req_chan.stack_word),
      .cmd              (cmd),
      .status           (status),
      .out_address      (rsp_chan.entry_address),
      .out_index        (rsp_chan.entry_index),
      .out_last         (rsp_chan.last_of_item),
      .out_full         (rsp_chan.list_full)
   );

endmodule

[sim/testbench.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the stack backtrace code filter.
module testbench import sbcf_pkg::*; ();

   localparam int LIST_DEPTH   = DEF_MAX_ENTRIES;
   localparam int LIST_IW      = $clog2(LIST_DEPTH);
   localparam int SCAN_LIMIT   = DEF_SCAN_WORDS;
   localparam int SPAN_BYTES   = 4 * SCAN_LIMIT;
   // worst item: take, evaluate, two results; leave some margin
   localparam int DRAIN_CYCLES = 8;
   // longest legitimate silence is the forced receiver hold-off plus a random stall tail
   localparam int HOLD_CYCLES  = 300;
   localparam int HANG_LIMIT   = 2000;

   typedef struct packed {
      logic              kind;
      logic [WORD_W-1:0] pc, lr, sp, word;
   } frame_req_type;

   typedef struct packed {
      logic [WORD_W-1:0]  addr;
      logic [INDEX_W-1:0] slot;
      logic               last;
      logic               full;
   } entry_type;

   // one row of the directed table; known rows carry their results typed in
   typedef struct packed {
      frame_req_type req;
      logic          known;
      logic [1:0]    count;
      entry_type     first;
      entry_type     second;
   } vector_type;

   logic              clock;
   logic              reset;
   logic              csr_write_enable;
   logic [CSR_W-1:0]  csr_index;
   logic [WORD_W-1:0] csr_data;

   sbcf_req_if req_chan ();
   sbcf_rsp_if rsp_chan ();

   stack_backtrace_code_filter #(
      .MAX_ENTRIES (LIST_DEPTH),
      .SCAN_WORDS  (SCAN_LIMIT)
   ) u_top (
      .clock            (clock),
      .reset            (reset),
      .req_chan         (req_chan),
      .rsp_chan         (rsp_chan),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   // ------------------------------------------------------------------
   // Call-list predictor: window registers, list contents and scan state
   // ------------------------------------------------------------------
   logic [WORD_W-1:0] code_base_q, code_end_q, ram_base_q, ram_end_q;
   logic [WORD_W-1:0] call_list_q [LIST_DEPTH];
   int unsigned       listed_count;
   int unsigned       words_scanned;
   bit                scan_on;

   entry_type   pending_entries [$];   // appended addresses still owed by the block
   vector_type  directed_rows [$];
   int unsigned failures;
   int unsigned items_counted;          // transactions accepted so far
   int          tx_gap_pct;
   int          rx_stall_pct;
   bit          hold_request;
   int          hold_left;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic bit is_code_addr(input logic [WORD_W-1:0] v);
      return v >= code_base_q && v < code_end_q && v[0];
   endfunction

   task automatic model_reset();
      code_base_q   = RST_CODE_BASE;
      code_end_q    = RST_CODE_END;
      ram_base_q    = RST_RAM_BASE;
      ram_end_q     = RST_RAM_END;
      listed_count  = 0;
      words_scanned = 0;
      scan_on       = 1'b0;
   endtask

   // Append to the list unless it is full, and record the emitted entry.
   task automatic add_entry(input logic [WORD_W-1:0] v, inout entry_type e0,
                            inout entry_type e1, inout int n);
      entry_type e;
      if (listed_count >= LIST_DEPTH)
         return;
      call_list_q[LIST_IW'(listed_count)] = v;
      e.addr = v;
      e.slot = INDEX_W'(listed_count);
      e.last = 1'b0;
      e.full = (listed_count + 1 >= LIST_DEPTH);
      if (n == 0)
         e0 = e;
      else
         e1 = e;
      n++;
      listed_count++;
   endtask

   task automatic predict_frame(input frame_req_type f, output entry_type e0,
                                output entry_type e1, output int n);
      logic [WORD_W:0] span_top;
      bit              dup;
      e0  = '0;
      e1  = '0;
      n   = 0;
      dup = 1'b0;
      if (f.kind == REQ_START) begin
         // no duplicate check between pc and lr
         listed_count  = 0;
         words_scanned = 0;
         if (is_code_addr(f.pc))
            add_entry(f.pc, e0, e1, n);
         if (is_code_addr(f.lr))
            add_entry(f.lr, e0, e1, n);
         // span end taken at 33 bits so a stack pointer near the top cannot wrap
         span_top = {1'b0, f.sp} + SPAN_BYTES;
         scan_on  = f.sp >= ram_base_q && f.sp < ram_end_q && span_top <= {1'b0, ram_end_q};
      end else if (scan_on && words_scanned < SCAN_LIMIT && listed_count < LIST_DEPTH) begin
         words_scanned++;
         for (int j = 0; j < listed_count; j++)
            if (call_list_q[LIST_IW'(j)] == f.word)
               dup = 1'b1;
         if (is_code_addr(f.word) && !dup)
            add_entry(f.word, e0, e1, n);
      end
      if (n == 1)
         e0.last = 1'b1;
      else if (n == 2)
         e1.last = 1'b1;
   endtask

   task automatic push_entries(input entry_type e0, input entry_type e1, input int n);
      if (n > 0)
         pending_entries.push_back(e0);
      if (n > 1)
         pending_entries.push_back(e1);
   endtask

   // ------------------------------------------------------------------
   // Request side
   // ------------------------------------------------------------------

   // Offer one transaction, hold it until taken, then predict what it causes.
   task automatic send_frame(input frame_req_type f, output entry_type e0,
                             output entry_type e1, output int n);
      while ($urandom_range(99) < tx_gap_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid         <= 1'b1;
      req_chan.req_type      <= f.kind;
      req_chan.fault_pc      <= f.pc;
      req_chan.link_value    <= f.lr;
      req_chan.stack_pointer <= f.sp;
      req_chan.stack_word    <= f.word;
      do
         @(posedge clock);
      while (!req_chan.ready);
      predict_frame(f, e0, e1, n);
   endtask

   task automatic issue(input frame_req_type f);
      entry_type e0, e1;
      int        n;
      send_frame(f, e0, e1, n);
      push_entries(e0, e1, n);
      items_counted++;
   endtask

   // Drop valid and hold off until every owed entry has been delivered.
   // Always waits on the clock before checking, so valid never gets two updates in a step.
   task automatic pause_until_drained();
      req_chan.valid <= 1'b0;
      do
         @(posedge clock);
      while (pending_entries.size() != 0);
   endtask

   task automatic write_reg(input logic [CSR_W-1:0] idx, input logic [WORD_W-1:0] val);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_data         <= val;
      @(posedge clock);
      case (idx)
         CSR_CODE_BASE: code_base_q = val;
         CSR_CODE_END:  code_end_q  = val;
         CSR_RAM_BASE:  ram_base_q  = val;
         CSR_RAM_END:   ram_end_q   = val;
         default: ;
      endcase
   endtask

   // Reprogram all four windows once the block has gone quiet. A word that
   // appends nothing may still be in evaluation, so wait out the latency too.
   task automatic apply_config(input logic [WORD_W-1:0] cb, input logic [WORD_W-1:0] ce,
                               input logic [WORD_W-1:0] rb, input logic [WORD_W-1:0] re);
      pause_until_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      write_reg(CSR_CODE_BASE, cb);
      write_reg(CSR_CODE_END, ce);
      write_reg(CSR_RAM_BASE, rb);
      write_reg(CSR_RAM_END, re);
      csr_write_enable <= 1'b0;
   endtask

   // ------------------------------------------------------------------
   // Stimulus generators, all relative to the current windows
   // ------------------------------------------------------------------
   function automatic logic [WORD_W-1:0] pick_code();
      logic [WORD_W-1:0] width_q;
      if (code_end_q <= code_base_q)
         return $urandom;
      width_q = code_end_q - code_base_q;
      return (code_base_q + ($urandom % width_q)) | 32'd1;
   endfunction

   function automatic logic [WORD_W-1:0] pick_non_code();
      case ($urandom_range(4))
         0:       return pick_code() & ~32'd1;   // even, inside the window
         1:       return code_base_q - 32'd1;    // just below
         2:       return code_end_q;             // exclusive end
         3:       return $urandom;
         default: return $urandom & ~32'd1;
      endcase
   endfunction

   function automatic logic [WORD_W-1:0] pick_word(input int code_pct);
      int r;
      r = $urandom_range(99);
      if (r < code_pct)
         return pick_code();
      if (r < code_pct + 15 && listed_count > 0)
         return call_list_q[LIST_IW'($urandom % listed_count)];   // repeat of a listed address
      return pick_non_code();
   endfunction

   function automatic logic [WORD_W-1:0] pick_sp(input bit well);
      logic [WORD_W:0] room;
      logic [WORD_W:0] off;
      room = {1'b0, ram_end_q} - {1'b0, ram_base_q};
      if (well && ram_end_q > ram_base_q && room >= SPAN_BYTES) begin
         off = $urandom % (room - SPAN_BYTES + 1);
         case ($urandom_range(3))
            0:       return ram_end_q - SPAN_BYTES;   // span ends exactly at the RAM end
            1:       return ram_base_q;
            default: return ram_base_q + (off[WORD_W-1:0] & ~32'd3);
         endcase
      end
      case ($urandom_range(4))
         0:       return ram_end_q - SPAN_BYTES + 32'd4;   // span overruns by one word
         1:       return ram_base_q - 32'd4;
         2:       return ram_end_q;
         3:       return 32'hFFFF_FFFC;
         default: return $urandom;
      endcase
   endfunction

   // One burst: usually a start followed by its stack words, sometimes bare noise.
   task automatic run_burst();
      frame_req_type f;
      int            sel;
      int            len;
      int            density;
      sel = $urandom_range(99);
      if (sel < 8) begin
         f.kind = 1'($urandom_range(1));
         f.pc   = $urandom;
         f.lr   = $urandom;
         f.sp   = $urandom;
         f.word = $urandom;
         issue(f);
         return;
      end
      f.kind = REQ_START;
      f.pc   = ($urandom_range(99) < 70) ? pick_code() : pick_non_code();
      f.lr   = ($urandom_range(99) < 70) ? pick_code() : pick_non_code();
      f.sp   = pick_sp($urandom_range(99) < 85);
      f.word = $urandom;
      issue(f);
      sel = $urandom_range(99);
      if (sel < 70) begin
         len     = $urandom_range(1, 20);
         density = 40;
      end else if (sel < 90) begin
         len     = $urandom_range(20, 60);
         density = 25;
      end else begin
         // sparse and long: runs into the word limit before the list fills
         len     = $urandom_range(SCAN_LIMIT - 2, SCAN_LIMIT + 12);
         density = 2;
      end
      repeat (len) begin
         f.kind = REQ_WORD;
         f.pc   = $urandom;
         f.lr   = $urandom;
         f.sp   = $urandom;
         f.word = pick_word(density);
         issue(f);
      end
      if ($urandom_range(5) == 0)
         pause_until_drained();
   endtask

   task automatic run_phase(input int gap_pct, input int stall_pct, input int quota);
      int unsigned target;
      tx_gap_pct   = gap_pct;
      rx_stall_pct = stall_pct;
      target       = items_counted + quota;
      while (items_counted < target)
         run_burst();
   endtask

   // ------------------------------------------------------------------
   // Directed table
   // ------------------------------------------------------------------
   function automatic entry_type listed_at(input logic [WORD_W-1:0] addr,
                                           input logic [INDEX_W-1:0] slot,
                                           input logic last);
      entry_type e;
      e.addr = addr;
      e.slot = slot;
      e.last = last;
      e.full = 1'b0;
      return e;
   endfunction

   task automatic add_row(input logic kind, input logic [WORD_W-1:0] pc,
                          input logic [WORD_W-1:0] lr, input logic [WORD_W-1:0] sp,
                          input logic [WORD_W-1:0] word, input logic known,
                          input logic [1:0] count, input entry_type a, input entry_type b);
      vector_type v;
      v.req.kind = kind;
      v.req.pc   = pc;
      v.req.lr   = lr;
      v.req.sp   = sp;
      v.req.word = word;
      v.known    = known;
      v.count    = count;
      v.first    = a;
      v.second   = b;
      directed_rows.push_back(v);
   endtask

   // Default windows: code 0800_0000..0810_0000, RAM 2000_0000..2002_0000.
   task automatic build_directed();
      entry_type none;
      none = '0;
      // word before any start: scanning is off
      add_row(REQ_WORD, 0, 0, 0, 32'h0800_0001, 1'b1, 2'd0, none, none);
      // same pc and lr are both listed
      add_row(REQ_START, 32'h0800_0001, 32'h0800_0001, 32'h2000_0000, 0, 1'b1, 2'd2,
              listed_at(32'h0800_0001, 4'd0, 1'b0), listed_at(32'h0800_0001, 4'd1, 1'b1));
      add_row(REQ_WORD, 0, 0, 0, 32'h0800_0001, 1'b1, 2'd0, none, none);   // already listed
      add_row(REQ_WORD, 0, 0, 0, 32'h0800_0000, 1'b1, 2'd0, none, none);   // even
      add_row(REQ_WORD, 0, 0, 0, 32'h07FF_FFFF, 1'b1, 2'd0, none, none);   // below window
      add_row(REQ_WORD, 0, 0, 0, 32'h0810_0001, 1'b1, 2'd0, none, none);   // past window
      add_row(REQ_WORD, 0, 0, 0, 32'h080F_FFFF, 1'b1, 2'd1,
              listed_at(32'h080F_FFFF, 4'd2, 1'b1), none);
      add_row(REQ_WORD, 0, 0, 0, 32'hFFFF_FFFF, 1'b1, 2'd0, none, none);
      // nothing listed, span ends exactly at the RAM end so scanning is on
      add_row(REQ_START, 32'h0000_0000, 32'hFFFF_FFFF, 32'h2001_FE00, 0, 1'b1, 2'd0,
              none, none);
      add_row(REQ_WORD, 0, 0, 0, 32'h0800_0011, 1'b1, 2'd1,
              listed_at(32'h0800_0011, 4'd0, 1'b1), none);
      // span overruns the RAM end by one word: scanning off
      add_row(REQ_START, 32'h0800_0005, 32'h0800_0002, 32'h2001_FE04, 0, 1'b1, 2'd1,
              listed_at(32'h0800_0005, 4'd0, 1'b1), none);
      add_row(REQ_WORD, 0, 0, 0, 32'h0800_0007, 1'b1, 2'd0, none, none);
      // stack pointer below RAM, only lr listed
      add_row(REQ_START, 32'h0000_0000, 32'h0800_0009, 32'h1FFF_FFFC, 0, 1'b1, 2'd1,
              listed_at(32'h0800_0009, 4'd0, 1'b1), none);
      // stack pointer at the top of the address space
      add_row(REQ_START, 32'h080F_FFFF, 32'h0810_0001, 32'hFFFF_FFFF, 0, 1'b1, 2'd1,
              listed_at(32'h080F_FFFF, 4'd0, 1'b1), none);
      add_row(REQ_START, 32'h0800_0001, 32'h0800_0003, 32'h2000_0100, 0, 1'b1, 2'd2,
              listed_at(32'h0800_0001, 4'd0, 1'b0), listed_at(32'h0800_0003, 4'd1, 1'b1));
      // fill the list to capacity; the predictor supplies these
      for (int k = 0; k < LIST_DEPTH - 2; k++)
         add_row(REQ_WORD, 0, 0, 0, 32'h0800_1001 + 32'(16 * k), 1'b0, 2'd0, none, none);
      // full list: ignored
      add_row(REQ_WORD, 0, 0, 0, 32'h0800_7777, 1'b1, 2'd0, none, none);
   endtask

   // ------------------------------------------------------------------
   // Result side: random back-pressure, forced hold-off, field checks
   // ------------------------------------------------------------------
   task automatic compare_field(input string name, input logic [WORD_W-1:0] want,
                                input logic [WORD_W-1:0] got);
      if (want !== got) begin
         failures++;
         $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
      end
   endtask

   task automatic check_entry();
      entry_type want;
      if (pending_entries.size() == 0) begin
         failures++;
         $display("%0t: unexpected entry: expected none, actual addr %h slot %0d", $time,
                  rsp_chan.entry_address, rsp_chan.entry_index);
         return;
      end
      want = pending_entries.pop_front();
      compare_field("entry_address", want.addr, rsp_chan.entry_address);
      compare_field("entry_index", WORD_W'(want.slot), WORD_W'(rsp_chan.entry_index));
      compare_field("last_of_item", WORD_W'(want.last), WORD_W'(rsp_chan.last_of_item));
      compare_field("list_full", WORD_W'(want.full), WORD_W'(rsp_chan.list_full));
   endtask

   initial begin
      rsp_chan.ready <= 1'b0;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (rsp_chan.valid && rsp_chan.ready)
            check_entry();
         // a hold-off request loads its own counter here
         if (hold_request) begin
            hold_left    = HOLD_CYCLES;
            hold_request = 1'b0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= ($urandom_range(99) >= rx_stall_pct);
         end
      end
   end

   // Watchdog: end the run if neither channel moves a transaction for too long.
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < HANG_LIMIT) begin
         @(posedge clock);
         if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("stack_backtrace_code_filter regression: fail");
      $finish;
   end

   // ------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------
   initial begin
      vector_type v;
      entry_type  e0, e1;
      int         n;

      reset                  <= 1'b1;
      csr_write_enable       <= 1'b0;
      csr_index              <= CSR_CODE_BASE;
      csr_data               <= '0;
      req_chan.valid         <= 1'b0;
      req_chan.req_type      <= REQ_START;
      req_chan.fault_pc      <= '0;
      req_chan.link_value    <= '0;
      req_chan.stack_pointer <= '0;
      req_chan.stack_word    <= '0;
      failures      = 0;
      items_counted = 0;
      tx_gap_pct    = 0;
      rx_stall_pct  = 0;
      hold_request  = 1'b0;
      model_reset();
      build_directed();

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed table at the reset windows, no idling on either side.
      foreach (directed_rows[i]) begin
         v = directed_rows[i];
         send_frame(v.req, e0, e1, n);
         if (v.known)
            push_entries(v.first, v.second, 32'(v.count));
         else
            push_entries(e0, e1, n);
         items_counted++;
      end

      // Random at reset windows; hold the receiver off for a long stretch at
      // the start so the block backs up and stalls the request side.
      hold_request = 1'b1;
      run_phase(0, 0, 140);

      // Whole address space is code and RAM; sender mostly idle.
      apply_config(32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF);
      run_phase(87, 0, 130);

      // Narrow code window for frequent repeats, RAM at the top; receiver mostly stalled.
      apply_config(32'h4000_0001, 32'h4000_0041, 32'hFFFF_0000, 32'hFFFF_FFFF);
      run_phase(0, 87, 130);

      // Empty code window, RAM exactly one span long; light idling on both sides.
      apply_config(32'hFFFF_FFFF, 32'h0000_0000, 32'h8000_0000, 32'h8000_0200);
      run_phase(8, 8, 40);

      // Low windows starting at zero.
      apply_config(32'h0000_0000, 32'h0000_1000, 32'h0000_0000, 32'h0000_0400);
      run_phase(8, 8, 80);

      // Drain, then give the block time to show any stray entry.
      pause_until_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      failures += pending_entries.size();

      if (failures == 0)
         $display("stack_backtrace_code_filter regression: pass");
      else
         $display("stack_backtrace_code_filter regression: fail");
      $finish;
   end

endmodule
